// ===== src/ddam_pkg.sv =====
// constants and types shared by the decimal digit array multiplier
// no dependencies
package ddam_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int DIGIT_W    = 4;
  localparam int DIG_AW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
  localparam int COL_DEPTH  = 2 * MAX_DIGITS;
  localparam int COL_AW     = $clog2(COL_DEPTH);
  localparam int TOT_W      = $clog2(COL_DEPTH + 1);
  localparam int COL_W      = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W    = RECIP_SHIFT + COL_W;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [TOT_W-1:0]   tot_t;

  localparam digit_t MAX_DEC  = digit_t'(9);
  localparam col_t   DEC_BASE = col_t'(10);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(6554);

endpackage

// ===== src/decimal_digit_array_multiplier.sv =====
// top level: schoolbook decimal multiplier with one shared multiply-accumulate unit
// depends on ddam_pkg and ddam_ram
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------
//   in      | in_valid/in_stall  | operand, digit, last
//   out     | out_valid/out_stall| product_digit, last_digit
//
// a digit beat is taken while in_stall is low; the beat marked last starts the product
// a product of la by lb digits, total = la + lb, runs column clear, then
//   multiply-accumulate, carry pass and readout in that order, all through
//   the single column ram port pair
// in_stall stays high from the last beat until the final product digit is taken
// out_stall holds the current product digit; rst is synchronous and clears control state
module decimal_digit_array_multiplier (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       operand,
  input  logic [3:0] digit,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] product_digit,
  output logic       last_digit
);
  import ddam_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_CLEAR, S_MAC_RD, S_MAC_WR, S_CR_RD, S_CR_SUM, S_CR_DIV, S_CR_WR,
    S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  state_t state;
  len_t len_a, len_b;
  tot_t total, k;
  logic [DIG_AW-1:0] ia, ib;
  col_t carry, v, q;

  logic in_acc;
  digit_t din;
  logic wr_a, wr_b;
  len_t len_a_next, len_b_next;
  tot_t total_next;

  digit_t rd_a, rd_b;
  col_t col_rd, col_wdata, col_sum, rem;
  logic col_we;
  logic [COL_AW-1:0] col_waddr, col_raddr, mac_col;
  logic [RECIP_W-1:0] recip_prod;
  logic [2*DIGIT_W-1:0] prod;

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign din      = (digit > MAX_DEC) ? MAX_DEC : digit;

  always_comb begin
    wr_a = in_acc && !operand && (len_a < len_t'(MAX_DIGITS));
    wr_b = in_acc && operand && (len_b < len_t'(MAX_DIGITS));
    len_a_next = wr_a ? len_t'(len_a + len_t'(1)) : len_a;
    len_b_next = wr_b ? len_t'(len_b + len_t'(1)) : len_b;
    total_next = tot_t'(len_a_next) + tot_t'(len_b_next);
  end

  ddam_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_first (
    .clk(clk), .we(wr_a), .waddr(len_a[DIG_AW-1:0]), .wdata(din),
    .raddr(ia), .rdata(rd_a)
  );

  ddam_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_second (
    .clk(clk), .we(wr_b), .waddr(len_b[DIG_AW-1:0]), .wdata(din),
    .raddr(ib), .rdata(rd_b)
  );

  ddam_ram #(.WIDTH(COL_W), .DEPTH(COL_DEPTH)) u_cols (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rd)
  );

  always_comb begin
    mac_col    = COL_AW'(tot_t'(ia) + tot_t'(ib) + tot_t'(1));
    prod       = rd_a * rd_b;
    col_sum    = col_t'(col_rd + col_t'(prod));
    recip_prod = RECIP_W'(v) * RECIP;
    rem        = col_t'(v - col_t'(q * DEC_BASE));
    col_we     = 1'b0;
    col_waddr  = k[COL_AW-1:0];
    col_wdata  = '0;
    col_raddr  = k[COL_AW-1:0];
    unique case (state)
      S_CLEAR: begin
        col_we = 1'b1;
      end
      S_MAC_RD: begin
        col_raddr = mac_col;
      end
      S_MAC_WR: begin
        col_we    = 1'b1;
        col_waddr = mac_col;
        col_raddr = mac_col;
        col_wdata = col_sum;
      end
      S_CR_WR: begin
        col_we    = 1'b1;
        col_wdata = rem;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      len_a     <= '0;
      len_b     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            len_a <= len_a_next;
            len_b <= len_b_next;
            if (last) begin
              total <= total_next;
              k     <= '0;
              state <= (total_next == '0) ? S_LOAD : S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (k == tot_t'(total - tot_t'(1))) begin
            ia    <= '0;
            ib    <= '0;
            k     <= tot_t'(total - tot_t'(1));
            carry <= '0;
            state <= (len_a != '0 && len_b != '0) ? S_MAC_RD : S_CR_RD;
          end else begin
            k <= tot_t'(k + tot_t'(1));
          end
        end
        S_MAC_RD: begin
          state <= S_MAC_WR;
        end
        S_MAC_WR: begin
          state <= S_MAC_RD;
          if (len_t'(ib) == len_t'(len_b - len_t'(1))) begin
            ib <= '0;
            if (len_t'(ia) == len_t'(len_a - len_t'(1))) begin
              state <= S_CR_RD;
            end else begin
              ia <= DIG_AW'(ia + 1'b1);
            end
          end else begin
            ib <= DIG_AW'(ib + 1'b1);
          end
        end
        S_CR_RD: begin
          state <= S_CR_SUM;
        end
        S_CR_SUM: begin
          v     <= col_t'(col_rd + carry);
          state <= S_CR_DIV;
        end
        S_CR_DIV: begin
          q     <= recip_prod[RECIP_SHIFT +: COL_W];
          state <= S_CR_WR;
        end
        S_CR_WR: begin
          carry <= q;
          if (k == '0) begin
            state <= S_OUT_RD;
          end else begin
            k     <= tot_t'(k - tot_t'(1));
            state <= S_CR_RD;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          product_digit <= col_rd[DIGIT_W-1:0];
          last_digit    <= (k == tot_t'(total - tot_t'(1)));
          out_valid     <= 1'b1;
          state         <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_digit) begin
              len_a <= '0;
              len_b <= '0;
              state <= S_LOAD;
            end else begin
              k     <= tot_t'(k + tot_t'(1));
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== src/ddam_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module ddam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
